/* hdl/dpvt_pkg.sv */
// Shared constants, types and helpers of the damped position/velocity tracker.
package dpvt_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int MAX_BLOCK_LENGTH = 4096;
  localparam int MIN_LEAD_SAMPLES = 96;
  localparam int MAX_LEAD_SAMPLES = 1440;

  localparam int POS_W    = 48;
  localparam int RATE_W   = 24;
  localparam int MAXR_W   = 23;
  localparam int GAIN_W   = 32;
  localparam int LEAD_W   = 12;
  localparam int BLEN_W   = 13;
  localparam int HOR_W    = 13;
  localparam int X_W      = 52;
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W + 1;
  localparam int ACC_W    = 83;
  localparam int DIV_W    = 50;
  localparam int DEN_W    = 49;
  localparam int DCNT_W   = $clog2(DIV_W + 1);
  localparam int SPLIT    = 24;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ABS_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LENGTH = 3'd6;

  localparam logic [OP_W-1:0] OP_SEEK  = 2'd0;
  localparam logic [OP_W-1:0] OP_BLOCK = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic signed [X_W-1:0] POS_MAX_X = X_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [X_W-1:0] POS_MIN_X = -POS_MAX_X - X_W'(1);
  localparam logic signed [X_W-1:0] RUNAWAY_SLACK_X = X_W'(256) <<< FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SEEK,
    S_B_M1, S_B_M2, S_B_H, S_B_DGO, S_B_DW, S_B_FIN,
    S_T_M1, S_T_M2, S_T_M3, S_T_RATE, S_T_DGO, S_T_DW, S_T_WRAP, S_T_GUARD
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SEEK,
    CMD_B_M1, CMD_B_M2, CMD_B_H, CMD_B_FIN,
    CMD_T_M1, CMD_T_M2, CMD_T_M3, CMD_T_RATE, CMD_T_WRAP, CMD_T_GUARD
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic div_start;
  } ctl_t;

  typedef struct packed {
    logic need_div;
    logic out_busy;
    logic div_done;
  } sts_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] s;
    begin
      s = v;
      if (v > POS_MAX_X) s = POS_MAX_X;
      if (v < POS_MIN_X) s = POS_MIN_X;
      sat_pos = s[POS_W-1:0];
    end
  endfunction

endpackage

/* hdl/dpvt_div.sv */
// Restoring divider, one quotient bit per cycle, for correction and loop wrap.
module dpvt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dpvt_pkg::DIV_W-1:0]   num,
  input  logic [dpvt_pkg::DEN_W-1:0]   den,
  output logic                         done,
  output logic [dpvt_pkg::DIV_W-1:0]   quo,
  output logic [dpvt_pkg::DEN_W-1:0]   rem
);

  logic [dpvt_pkg::DIV_W-1:0]  quo_r;
  logic [dpvt_pkg::DEN_W-1:0]  rem_r, den_r;
  logic [dpvt_pkg::DCNT_W-1:0] cnt_r;
  logic                        done_r;
  logic [dpvt_pkg::DEN_W:0]    rem_sh, rem_sub;
  logic                        ge;

  assign rem_sh  = {rem_r, quo_r[dpvt_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= dpvt_pkg::DCNT_W'(dpvt_pkg::DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == dpvt_pkg::DCNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[dpvt_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[dpvt_pkg::DEN_W-1:0] : rem_sh[dpvt_pkg::DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/dpvt_ctrl.sv */
// Sequencer for seek, block start and tick items.
module dpvt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [dpvt_pkg::OP_W-1:0]  in_op,
  input  dpvt_pkg::sts_t             sts,
  output logic                       in_tready,
  output dpvt_pkg::ctl_t             ctl
);

  dpvt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dpvt_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpvt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == dpvt_pkg::OP_SEEK)       state_nxt = dpvt_pkg::S_SEEK;
          else if (in_op == dpvt_pkg::OP_BLOCK) state_nxt = dpvt_pkg::S_B_M1;
          else if (in_op == dpvt_pkg::OP_TICK)  state_nxt = dpvt_pkg::S_T_M1;
        end
      end
      dpvt_pkg::S_SEEK:  state_nxt = dpvt_pkg::S_IDLE;
      dpvt_pkg::S_B_M1:  state_nxt = dpvt_pkg::S_B_M2;
      dpvt_pkg::S_B_M2:  state_nxt = dpvt_pkg::S_B_H;
      dpvt_pkg::S_B_H:   state_nxt = dpvt_pkg::S_B_DGO;
      dpvt_pkg::S_B_DGO: state_nxt = dpvt_pkg::S_B_DW;
      dpvt_pkg::S_B_DW:  if (sts.div_done) state_nxt = dpvt_pkg::S_B_FIN;
      dpvt_pkg::S_B_FIN: state_nxt = dpvt_pkg::S_IDLE;
      dpvt_pkg::S_T_M1:  state_nxt = dpvt_pkg::S_T_M2;
      dpvt_pkg::S_T_M2:  state_nxt = dpvt_pkg::S_T_M3;
      dpvt_pkg::S_T_M3:  state_nxt = dpvt_pkg::S_T_RATE;
      dpvt_pkg::S_T_RATE:
        state_nxt = sts.need_div ? dpvt_pkg::S_T_DGO : dpvt_pkg::S_T_WRAP;
      dpvt_pkg::S_T_DGO: state_nxt = dpvt_pkg::S_T_DW;
      dpvt_pkg::S_T_DW:  if (sts.div_done) state_nxt = dpvt_pkg::S_T_WRAP;
      dpvt_pkg::S_T_WRAP: state_nxt = dpvt_pkg::S_T_GUARD;
      dpvt_pkg::S_T_GUARD: if (!sts.out_busy) state_nxt = dpvt_pkg::S_IDLE;
      default: state_nxt = dpvt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    ctl.cmd       = dpvt_pkg::CMD_NONE;
    ctl.div_start = 1'b0;
    case (state_r)
      dpvt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        ctl.cmd   = dpvt_pkg::CMD_LOAD;
      end
      dpvt_pkg::S_SEEK:   ctl.cmd = dpvt_pkg::CMD_SEEK;
      dpvt_pkg::S_B_M1:   ctl.cmd = dpvt_pkg::CMD_B_M1;
      dpvt_pkg::S_B_M2:   ctl.cmd = dpvt_pkg::CMD_B_M2;
      dpvt_pkg::S_B_H:    ctl.cmd = dpvt_pkg::CMD_B_H;
      dpvt_pkg::S_B_DGO:  ctl.div_start = 1'b1;
      dpvt_pkg::S_B_FIN:  ctl.cmd = dpvt_pkg::CMD_B_FIN;
      dpvt_pkg::S_T_M1:   ctl.cmd = dpvt_pkg::CMD_T_M1;
      dpvt_pkg::S_T_M2:   ctl.cmd = dpvt_pkg::CMD_T_M2;
      dpvt_pkg::S_T_M3:   ctl.cmd = dpvt_pkg::CMD_T_M3;
      dpvt_pkg::S_T_RATE: ctl.cmd = dpvt_pkg::CMD_T_RATE;
      dpvt_pkg::S_T_DGO:  ctl.div_start = 1'b1;
      dpvt_pkg::S_T_WRAP: ctl.cmd = dpvt_pkg::CMD_T_WRAP;
      dpvt_pkg::S_T_GUARD: if (!sts.out_busy) ctl.cmd = dpvt_pkg::CMD_T_GUARD;
      default: ctl.cmd = dpvt_pkg::CMD_NONE;
    endcase
  end

endmodule

/* hdl/dpvt_dp.sv */
// Tracker datapath: state, settings, shared multiplier and result register.
module dpvt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dpvt_pkg::ctl_t                      ctl,
  output dpvt_pkg::sts_t                      sts,
  input  logic                                in_tvalid,
  input  logic [dpvt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_valid,
  input  logic [dpvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpvt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                div_done,
  input  logic [dpvt_pkg::DIV_W-1:0]          div_quo,
  input  logic [dpvt_pkg::DEN_W-1:0]          div_rem,
  output logic [dpvt_pkg::DIV_W-1:0]          div_num,
  output logic [dpvt_pkg::DEN_W-1:0]          div_den,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dpvt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [0:0]                          out_tuser
);

  localparam int PW = dpvt_pkg::POS_W;
  localparam int RW = dpvt_pkg::RATE_W;
  localparam int XW = dpvt_pkg::X_W;
  localparam int FB = dpvt_pkg::FRAC_BITS;

  function automatic logic [dpvt_pkg::DIV_W-1:0] DIV_W_SLICE(input logic signed [XW-1:0] v);
    DIV_W_SLICE = v[dpvt_pkg::DIV_W-1:0];
  endfunction

  // settings
  logic [dpvt_pkg::MAXR_W-1:0] maxr_r;
  logic [dpvt_pkg::GAIN_W-1:0] pg_r, vg_r;
  logic                        le_r;
  logic [31:0]                 ls_r, lend_r, tl_r;

  // tracker state
  logic signed [PW-1:0] hp_r, mt_r, bt_r, corr_r, tlim_r;
  logic signed [RW-1:0] hr_r, rr_r;
  logic                 valid_r;
  logic [dpvt_pkg::HOR_W-1:0] lh_r;

  // latched item and scratch
  logic signed [PW-1:0]        ipos_r, hand_r, shown_r;
  logic signed [RW-1:0]        icr_r, rnew_r;
  logic [dpvt_pkg::LEAD_W-1:0] ilead_r;
  logic [dpvt_pkg::BLEN_W-1:0] iblen_r;
  logic signed [dpvt_pkg::MUL_P_W-1:0] mul_p_r;
  logic signed [dpvt_pkg::ACC_W-1:0]   acc_r;
  logic [dpvt_pkg::DIV_W-1:0] div_num_r;
  logic [dpvt_pkg::DEN_W-1:0] div_den_r;
  logic                       div_neg_r;

  logic                 out_valid_r, out_flag_r;
  logic signed [RW-1:0] out_rate_r;
  logic signed [PW-1:0] out_pos_r;

  // item fields
  logic signed [RW:0]           maxr_x, icr_x;
  logic signed [RW-1:0]         rr_c;
  logic [dpvt_pkg::LEAD_W-1:0]  lead_c;
  logic [dpvt_pkg::BLEN_W-1:0]  n_c;
  logic [dpvt_pkg::HOR_W-1:0]   lh_c;
  logic signed [PW-1:0]         tgt_c;

  assign maxr_x = $signed({2'b00, maxr_r});
  assign icr_x  = {icr_r[RW-1], icr_r};

  always_comb begin
    if (icr_x > maxr_x)       rr_c = maxr_x[RW-1:0];
    else if (icr_x < -maxr_x) rr_c = RW'(-maxr_x);
    else                      rr_c = icr_r;
    if (ilead_r < dpvt_pkg::LEAD_W'(dpvt_pkg::MIN_LEAD_SAMPLES))
      lead_c = dpvt_pkg::LEAD_W'(dpvt_pkg::MIN_LEAD_SAMPLES);
    else if (ilead_r > dpvt_pkg::LEAD_W'(dpvt_pkg::MAX_LEAD_SAMPLES))
      lead_c = dpvt_pkg::LEAD_W'(dpvt_pkg::MAX_LEAD_SAMPLES);
    else
      lead_c = ilead_r;
    if (iblen_r == '0)
      n_c = dpvt_pkg::BLEN_W'(1);
    else if (iblen_r > dpvt_pkg::BLEN_W'(dpvt_pkg::MAX_BLOCK_LENGTH))
      n_c = dpvt_pkg::BLEN_W'(dpvt_pkg::MAX_BLOCK_LENGTH);
    else
      n_c = iblen_r;
  end

  assign lh_c  = dpvt_pkg::HOR_W'(lead_c) + dpvt_pkg::HOR_W'(n_c);
  assign tgt_c = ipos_r[PW-1] ? '0 : ipos_r;

  // widened views
  logic signed [XW-1:0] hp_x, mt_x, bt_x, corr_x, tlim_x, hr_x, rr_x, rnew_x, prod_x;
  assign hp_x   = XW'(hp_r);
  assign mt_x   = XW'(mt_r);
  assign bt_x   = XW'(bt_r);
  assign corr_x = XW'(corr_r);
  assign tlim_x = XW'(tlim_r);
  assign hr_x   = XW'(hr_r);
  assign rr_x   = XW'(rr_r);
  assign rnew_x = XW'(rnew_r);
  assign prod_x = XW'(mul_p_r);

  logic signed [XW-1:0] err_x;
  logic signed [RW:0]   dvel;
  assign err_x = mt_x - hp_x;
  assign dvel  = {rr_r[RW-1], rr_r} - {hr_r[RW-1], hr_r};

  // runaway bound magnitude
  logic [RW-1:0] abs_rr, abs_rn, mag;
  assign abs_rr = rr_r[RW-1]   ? RW'(-rr_r)   : rr_r;
  assign abs_rn = rnew_r[RW-1] ? RW'(-rnew_r) : rnew_r;
  assign mag    = (abs_rr > abs_rn) ? abs_rr : abs_rn;

  // shared multiplier, signed A by unsigned B, registered
  logic signed [dpvt_pkg::MUL_A_W-1:0] mul_a;
  logic [dpvt_pkg::MUL_B_W-1:0]        mul_b;
  logic                                mul_en;
  logic signed [dpvt_pkg::MUL_B_W:0]   mul_bs;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (ctl.cmd)
      dpvt_pkg::CMD_B_M1: begin
        mul_a = dpvt_pkg::MUL_A_W'(rr_c);
        mul_b = dpvt_pkg::MUL_B_W'(lead_c);
      end
      dpvt_pkg::CMD_B_M2: begin
        mul_a = dpvt_pkg::MUL_A_W'(rr_c);
        mul_b = dpvt_pkg::MUL_B_W'(lh_c);
      end
      dpvt_pkg::CMD_T_M1: begin
        mul_a = $signed({1'b0, err_x[dpvt_pkg::SPLIT-1:0]});
        mul_b = pg_r;
      end
      dpvt_pkg::CMD_T_M2: begin
        mul_a = err_x[dpvt_pkg::SPLIT+dpvt_pkg::MUL_A_W-1:dpvt_pkg::SPLIT];
        mul_b = pg_r;
      end
      dpvt_pkg::CMD_T_M3: begin
        mul_a = dpvt_pkg::MUL_A_W'(dvel);
        mul_b = vg_r;
      end
      dpvt_pkg::CMD_T_WRAP: begin
        mul_a = $signed({1'b0, mag});
        mul_b = dpvt_pkg::MUL_B_W'(lh_r);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_bs = $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    if (mul_en) mul_p_r <= mul_a * mul_bs;
  end

  // rate update
  logic signed [XW-1:0] p1_x, p2_x, rsum;
  logic signed [RW-1:0] rclamp;
  logic signed [XW-1:0] maxr_w;
  assign p1_x   = XW'($signed(acc_r[dpvt_pkg::ACC_W-1:32]));
  assign p2_x   = XW'($signed(mul_p_r[dpvt_pkg::MUL_P_W-1:32]));
  assign rsum   = hr_x + p1_x + p2_x;
  assign maxr_w = XW'(maxr_x);

  always_comb begin
    if (rsum > maxr_w)       rclamp = maxr_x[RW-1:0];
    else if (rsum < -maxr_w) rclamp = RW'(-maxr_x);
    else                     rclamp = rsum[RW-1:0];
  end

  // loop wrap and track clamp
  logic                 loop_use, track_clamp;
  logic [31:0]          span, tl_m1;
  logic signed [XW-1:0] base_x, len_x, d_x, dpl_x, top_x, rem_x, off_x, shown_x;
  logic                 in_fwd, in_back;
  logic signed [PW-1:0] top_p, shown_c, hp_nxt_c;

  assign loop_use    = le_r && ({1'b0, lend_r} > ({1'b0, ls_r} + 33'd1));
  assign span        = lend_r - ls_r;
  assign tl_m1       = tl_r - 32'd1;
  assign track_clamp = tl_r > 32'd1;
  assign base_x = $signed({{(XW-32-FB){1'b0}}, ls_r, {FB{1'b0}}});
  assign len_x  = $signed({{(XW-32-FB){1'b0}}, span, {FB{1'b0}}});
  assign top_x  = $signed({{(XW-32-FB){1'b0}}, tl_m1, {FB{1'b0}}});
  assign top_p  = dpvt_pkg::sat_pos(top_x);
  assign d_x    = hp_x - base_x;
  assign dpl_x  = d_x + len_x;
  assign in_fwd  = !d_x[XW-1] && (d_x < len_x);
  assign in_back = d_x[XW-1] && !dpl_x[XW-1];
  assign rem_x   = $signed({{(XW-dpvt_pkg::DEN_W){1'b0}}, div_rem});

  always_comb begin
    if (in_fwd)                           off_x = d_x;
    else if (in_back)                     off_x = dpl_x;
    else if (d_x[XW-1] && div_rem != '0)  off_x = len_x - rem_x;
    else                                  off_x = rem_x;
    if (loop_use) begin
      shown_x = base_x + off_x;
      shown_c = dpvt_pkg::sat_pos(shown_x);
    end else begin
      shown_x = '0;
      shown_c = hp_r[PW-1] ? '0 : hp_r;
      if (track_clamp && shown_c > top_p) shown_c = top_p;
    end
  end

  assign hp_nxt_c = dpvt_pkg::sat_pos(XW'(shown_c) + rnew_x);

  // moving target
  logic signed [PW-1:0] mt_adv, mt_cap;
  assign mt_adv = dpvt_pkg::sat_pos(mt_x + rr_x + corr_x);
  always_comb begin
    mt_cap = mt_adv;
    if (!rr_r[RW-1]) begin
      if (mt_adv > tlim_r) mt_cap = tlim_r;
    end else begin
      if (mt_adv < tlim_r) mt_cap = tlim_r;
    end
  end

  // block start
  logic signed [PW-1:0] mt_eff;
  logic signed [XW-1:0] bdiff, bmag, quo_x;
  assign mt_eff = valid_r ? mt_r : hand_r;
  assign bdiff  = XW'(hand_r) - XW'(mt_eff);
  assign bmag   = bdiff[XW-1] ? -bdiff : bdiff;
  assign quo_x  = $signed({{(XW-dpvt_pkg::DIV_W){1'b0}}, div_quo});

  // runaway guard
  logic signed [XW-1:0] bound_x, lead_x;
  logic                 over, under, out_free;
  assign bound_x  = (prod_x <<< 2) + dpvt_pkg::RUNAWAY_SLACK_X;
  assign lead_x   = hp_x - bt_x;
  assign over     = !le_r && (lead_x > bound_x);
  assign under    = !le_r && !over && (lead_x < -bound_x);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxr_r <= dpvt_pkg::MAXR_W'(262144);
      pg_r   <= dpvt_pkg::GAIN_W'(198996);
      vg_r   <= dpvt_pkg::GAIN_W'(58469881);
      le_r   <= 1'b0;
      ls_r   <= '0;
      lend_r <= '0;
      tl_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpvt_pkg::REG_MAX_ABS_RATE: maxr_r <= cfg_data[dpvt_pkg::MAXR_W-1:0];
        dpvt_pkg::REG_POS_GAIN:     pg_r   <= cfg_data;
        dpvt_pkg::REG_VEL_GAIN:     vg_r   <= cfg_data;
        dpvt_pkg::REG_LOOP_ENABLE:  le_r   <= cfg_data[0];
        dpvt_pkg::REG_LOOP_START:   ls_r   <= cfg_data;
        dpvt_pkg::REG_LOOP_END:     lend_r <= cfg_data;
        dpvt_pkg::REG_TRACK_LENGTH: tl_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r    <= '0;
      hr_r    <= '0;
      mt_r    <= '0;
      valid_r <= 1'b0;
      bt_r    <= '0;
      rr_r    <= '0;
      corr_r  <= '0;
      tlim_r  <= '0;
      lh_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && ctl.cmd != dpvt_pkg::CMD_T_GUARD)
        out_valid_r <= 1'b0;
      case (ctl.cmd)
        dpvt_pkg::CMD_SEEK: begin
          hp_r    <= ipos_r;
          hr_r    <= icr_r;
          valid_r <= 1'b0;
        end
        dpvt_pkg::CMD_B_H: begin
          mt_r    <= mt_eff;
          valid_r <= 1'b1;
          bt_r    <= tgt_c;
          rr_r    <= rr_c;
          lh_r    <= lh_c;
          tlim_r  <= dpvt_pkg::sat_pos(XW'(tgt_c) + prod_x);
        end
        dpvt_pkg::CMD_B_FIN:
          corr_r <= dpvt_pkg::sat_pos(div_neg_r ? -quo_x : quo_x);
        dpvt_pkg::CMD_T_RATE:
          hr_r <= rclamp;
        dpvt_pkg::CMD_T_WRAP: begin
          hp_r <= hp_nxt_c;
          mt_r <= mt_cap;
        end
        dpvt_pkg::CMD_T_GUARD: begin
          if (over) begin
            hp_r <= dpvt_pkg::sat_pos(bt_x + bound_x);
            if (hr_r > rr_r) hr_r <= rr_r;
          end else if (under) begin
            hp_r <= dpvt_pkg::sat_pos(bt_x - bound_x);
            if (hr_r < rr_r) hr_r <= rr_r;
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      dpvt_pkg::CMD_LOAD: begin
        if (in_tvalid) begin
          ipos_r  <= in_tdata[PW-1:0];
          icr_r   <= in_tdata[PW+RW-1:PW];
          ilead_r <= in_tdata[PW+RW+dpvt_pkg::LEAD_W-1:PW+RW];
          iblen_r <= in_tdata[PW+RW+dpvt_pkg::LEAD_W+dpvt_pkg::BLEN_W-1:
                              PW+RW+dpvt_pkg::LEAD_W];
        end
      end
      dpvt_pkg::CMD_B_M2:
        hand_r <= dpvt_pkg::sat_pos(XW'(tgt_c) + prod_x);
      dpvt_pkg::CMD_B_H: begin
        div_num_r <= bmag[dpvt_pkg::DIV_W-1:0];
        div_den_r <= dpvt_pkg::DEN_W'(n_c);
        div_neg_r <= bdiff[XW-1];
      end
      dpvt_pkg::CMD_T_M2:
        acc_r <= dpvt_pkg::ACC_W'(mul_p_r);
      dpvt_pkg::CMD_T_M3:
        acc_r <= acc_r + (dpvt_pkg::ACC_W'(mul_p_r) <<< dpvt_pkg::SPLIT);
      dpvt_pkg::CMD_T_RATE: begin
        rnew_r    <= rclamp;
        div_num_r <= d_x[XW-1] ? DIV_W_SLICE(-d_x) : DIV_W_SLICE(d_x);
        div_den_r <= len_x[dpvt_pkg::DEN_W-1:0];
      end
      dpvt_pkg::CMD_T_WRAP:
        shown_r <= shown_c;
      dpvt_pkg::CMD_T_GUARD: begin
        out_rate_r <= rnew_r;
        out_pos_r  <= shown_r;
        out_flag_r <= over || under;
      end
      default: ;
    endcase
  end

  assign sts.need_div = loop_use && !in_fwd && !in_back;
  assign sts.out_busy = !out_free;
  assign sts.div_done = div_done;

  assign div_num    = div_num_r;
  assign div_den    = div_den_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_rate_r};
  assign out_tuser  = out_flag_r;

endmodule

/* hdl/damped_position_velocity_tracker_core.sv */
// Top level of the damped position/velocity tracker for a scratch read head.
//
// Channels: the input stream carries one command word per handshake, its kind in
// in_tuser (seek, block start, tick). Seek and block start words change state and
// give no result; each tick word gives exactly one result word on the output
// stream: clamped rate, wrapped read position and the runaway guard flag.
// Configuration words arrive on the cfg_ channel (index, data), always ready; write
// them only while the block is idle.
// Steps: the block takes one word at a time. A seek loads head position and rate;
// a block start forms its products, then divides its correction by the block
// length in the bit-serial divider. A tick forms its gain products and new rate,
// then wraps and guards the read position; while the loop is in use and that
// position is over a loop length from the loop start, the divider takes the modulo.
// The shared 25 x 33 multiplier carries three products per tick plus the guard.
// Reset (rst_n low, synchronous) clears the head, the hand reference and the
// output register, and loads the default gains and rate clamp.
// Stall: a finished result waits in the output register; the next word is taken
// meanwhile, and a following tick holds in its last step until that register frees.
module damped_position_velocity_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, low bit up: position[47:0], commanded_rate[71:48],
  // lead_samples[83:72], block_length[96:84], zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dpvt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: operation[1:0]
  input  logic [dpvt_pkg::OP_W-1:0]           in_tuser,
  // out_tdata, low bit up: rate[23:0], read_position[71:24]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dpvt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: lead_limited[0]
  output logic [0:0]                          out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpvt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dpvt_pkg::ctl_t ctl;
  dpvt_pkg::sts_t sts;

  logic                       div_done;
  logic [dpvt_pkg::DIV_W-1:0] div_quo, div_num;
  logic [dpvt_pkg::DEN_W-1:0] div_rem, div_den;

  // settings are always writable
  assign cfg_ready = 1'b1;

  dpvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  dpvt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  dpvt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .div_rem    (div_rem),
    .div_num    (div_num),
    .div_den    (div_den),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // the divider never finishes in the cycle right after its start
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |=> !div_done)
    else $error("divider finished one cycle after start");

  // a tick keeps the input closed on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == dpvt_pkg::OP_TICK) |=> !in_tready)
    else $error("input reopened during a tick");

  // a new result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == dpvt_pkg::CMD_T_GUARD) |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while stalled");
`endif

endmodule

/* tb/damped_position_velocity_tracker_core_tb.sv */
// Self-checking testbench for the damped position/velocity tracker core.
module damped_position_velocity_tracker_core_tb;

  localparam logic [dpvt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint POS_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint POS_LO = -POS_HI - 1;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASES = 8;

  typedef struct {
    logic [dpvt_pkg::OP_W-1:0]           op;
    logic signed [dpvt_pkg::POS_W-1:0]   pos;
    logic signed [dpvt_pkg::RATE_W-1:0]  rate;
    logic [dpvt_pkg::LEAD_W-1:0]         lead;
    logic [dpvt_pkg::BLEN_W-1:0]         blen;
  } cmd_word_t;

  typedef struct {
    logic [dpvt_pkg::RATE_W-1:0] rate;
    logic [dpvt_pkg::POS_W-1:0]  rpos;
    logic                        guard;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [dpvt_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [dpvt_pkg::OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dpvt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dpvt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dpvt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  damped_position_velocity_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the tracker: configuration and head/reference state.
  longint c_maxr, c_pgain, c_vgain, c_loop_en, c_lstart, c_lend, c_tlen;
  longint head_pos, head_rate, mov_tgt, blk_tgt, ref_rate, tgt_corr, tgt_lim, horizon;
  bit     ref_ok;

  cmd_word_t pending_words[$];
  sample_t   expected_samples[$];
  cmd_word_t cur_word;
  int errors = 0;
  int words_sent = 0;
  int samples_checked = 0;
  bit no_idle = 1'b0;

  function automatic longint sat48(input longint v);
    return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
  endfunction

  function automatic longint clampv(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(a * g / 2^32), split so the low half product stays unsigned
  function automatic longint gain_mul(input longint a, input longint g);
    longint unsigned lo;
    longint hi;
    longint unsigned gu;
    lo = a & 64'hFFFF_FFFF;
    hi = (a - longint'(lo)) >>> 32;
    gu = g;
    return hi * g + longint'((lo * gu) >> 32);
  endfunction

  function automatic longint wrap_head(input longint p);
    longint base, len, o, top;
    if (c_loop_en != 0 && c_lend > c_lstart + 1) begin
      base = c_lstart <<< dpvt_pkg::FRAC_BITS;
      len = (c_lend - c_lstart) <<< dpvt_pkg::FRAC_BITS;
      o = (p - base) % len;
      if (o < 0) o += len;
      return sat48(base + o);
    end
    if (p < 0) p = 0;
    if (c_tlen <= 1) return p;
    top = sat48((c_tlen - 1) <<< dpvt_pkg::FRAC_BITS);
    return p > top ? top : p;
  endfunction

  task automatic reset_tracker();
    c_maxr = 262144; c_pgain = 198996; c_vgain = 58469881;
    c_loop_en = 0; c_lstart = 0; c_lend = 0; c_tlen = 0;
    head_pos = 0; head_rate = 0; mov_tgt = 0; ref_ok = 0;
    blk_tgt = 0; ref_rate = 0; tgt_corr = 0; tgt_lim = 0; horizon = 0;
  endtask

  // Advance the shadow by one accepted command word; ticks queue a sample.
  task automatic track_word(input cmd_word_t w);
    longint p, cr, lead, n, tgt, rr, hand, r, shown, ar, ah, bound, lead_d;
    sample_t s;
    p = longint'(w.pos);
    cr = longint'(w.rate);
    case (w.op)
      dpvt_pkg::OP_SEEK: begin
        head_pos = p; head_rate = cr; ref_ok = 0;
      end
      dpvt_pkg::OP_BLOCK: begin
        tgt = p < 0 ? 0 : p;
        rr = clampv(cr, -c_maxr, c_maxr);
        lead = clampv(longint'(w.lead), dpvt_pkg::MIN_LEAD_SAMPLES,
                      dpvt_pkg::MAX_LEAD_SAMPLES);
        n = clampv(longint'(w.blen), 1, dpvt_pkg::MAX_BLOCK_LENGTH);
        hand = sat48(tgt + rr * lead);
        if (!ref_ok) begin
          mov_tgt = hand; ref_ok = 1;
        end
        blk_tgt = tgt;
        ref_rate = rr;
        horizon = lead + n;
        tgt_lim = sat48(tgt + rr * horizon);
        tgt_corr = sat48((hand - mov_tgt) / n);
      end
      dpvt_pkg::OP_TICK: begin
        r = head_rate + gain_mul(mov_tgt - head_pos, c_pgain)
            + gain_mul(ref_rate - head_rate, c_vgain);
        r = clampv(r, -c_maxr, c_maxr);
        head_rate = r;
        head_pos = wrap_head(head_pos);
        shown = head_pos;
        head_pos = sat48(head_pos + r);
        mov_tgt = sat48(mov_tgt + ref_rate + tgt_corr);
        if (ref_rate >= 0) begin
          if (mov_tgt > tgt_lim) mov_tgt = tgt_lim;
        end else begin
          if (mov_tgt < tgt_lim) mov_tgt = tgt_lim;
        end
        s.guard = 1'b0;
        // runaway guard only outside a loop
        if (c_loop_en == 0) begin
          ar = ref_rate < 0 ? -ref_rate : ref_rate;
          ah = head_rate < 0 ? -head_rate : head_rate;
          bound = (ar > ah ? ar : ah) * horizon * 4
                  + (longint'(256) <<< dpvt_pkg::FRAC_BITS);
          lead_d = head_pos - blk_tgt;
          if (lead_d > bound) begin
            head_pos = sat48(blk_tgt + bound);
            if (head_rate > ref_rate) head_rate = ref_rate;
            s.guard = 1'b1;
          end else if (lead_d < -bound) begin
            head_pos = sat48(blk_tgt - bound);
            if (head_rate < ref_rate) head_rate = ref_rate;
            s.guard = 1'b1;
          end
        end
        s.rate = r[dpvt_pkg::RATE_W-1:0];
        s.rpos = shown[dpvt_pkg::POS_W-1:0];
        expected_samples.push_back(s);
      end
      default: ;
    endcase
  endtask

  // Mostly no gap, some short ones, a few long stretches.
  function automatic int idle_len();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(99);
    if (k < 65) return 0;
    if (k < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Input driver: hold a word until taken, then advance after a random gap.
  int in_gap = 0;
  bit in_taken = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        in_tuser <= cur_word.op;
        in_tdata <= {7'd0, cur_word.blen, cur_word.lead, cur_word.rate, cur_word.pos};
        in_tvalid <= 1'b1;
        in_gap <= idle_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Accept side of the input: advance the shadow on each handshake.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      track_word(cur_word);
      words_sent++;
    end
  end

  // Result receiver: random stalls.
  int out_stall = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall <= idle_len();
    end
  end

  // Compare every result word against the oldest expected sample.
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result word rate=%h read_position=%h", out_tdata[23:0],
               out_tdata[71:24]);
        errors++;
      end else begin
        e = expected_samples.pop_front();
        samples_checked++;
        if (out_tdata[23:0] !== e.rate) begin
          $error("rate: expected %h, got %h", e.rate, out_tdata[23:0]);
          errors++;
        end
        if (out_tdata[71:24] !== e.rpos) begin
          $error("read_position: expected %h, got %h", e.rpos, out_tdata[71:24]);
          errors++;
        end
        if (out_tuser[0] !== e.guard) begin
          $error("lead_limited: expected %b, got %b", e.guard, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [dpvt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dpvt_pkg::REG_MAX_ABS_RATE: c_maxr = val & 32'h7F_FFFF;
      dpvt_pkg::REG_POS_GAIN:     c_pgain = val;
      dpvt_pkg::REG_VEL_GAIN:     c_vgain = val;
      dpvt_pkg::REG_LOOP_ENABLE:  c_loop_en = val & 32'd1;
      dpvt_pkg::REG_LOOP_START:   c_lstart = val;
      dpvt_pkg::REG_LOOP_END:     c_lend = val;
      dpvt_pkg::REG_TRACK_LENGTH: c_tlen = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Let the block run dry: nothing queued, nothing expected, then settle.
  task automatic drain();
    while (pending_words.size() > 0 || in_tvalid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_word(input logic [dpvt_pkg::OP_W-1:0] op,
                           input logic signed [dpvt_pkg::POS_W-1:0] p,
                           input logic signed [dpvt_pkg::RATE_W-1:0] r,
                           input logic [dpvt_pkg::LEAD_W-1:0] l,
                           input logic [dpvt_pkg::BLEN_W-1:0] n);
    cmd_word_t w;
    w.op = op; w.pos = p; w.rate = r; w.lead = l; w.blen = n;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick32(input logic [31:0] typical);
    int k;
    k = $urandom_range(9);
    if (k == 0) return 32'd0;
    if (k == 1) return 32'hFFFF_FFFF;
    if (k == 2) return $urandom;
    return typical;
  endfunction

  // Positions: mostly near the loop or the start of the track, some anywhere.
  function automatic logic signed [dpvt_pkg::POS_W-1:0] rnd_pos();
    int k;
    longint base;
    k = $urandom_range(99);
    base = c_lstart <<< dpvt_pkg::FRAC_BITS;
    if (k < 35) return dpvt_pkg::POS_W'($urandom_range(32'h3FF_FFFF));
    if (k < 60)
      return dpvt_pkg::POS_W'(base + longint'($urandom_range(32'h1FFF_FFFF)) - 64'h800_0000);
    if (k < 80) return dpvt_pkg::POS_W'({$urandom, $urandom} >> 16);
    if (k < 85) return 48'sh7FFF_FFFF_FFFF;
    if (k < 90) return 48'sh8000_0000_0000;
    return -dpvt_pkg::POS_W'($urandom_range(32'hFF_FFFF));
  endfunction

  function automatic logic signed [dpvt_pkg::RATE_W-1:0] rnd_rate();
    int k;
    k = $urandom_range(9);
    if (k < 5) return dpvt_pkg::RATE_W'(int'($urandom_range(32'h2_0000)) - 32'h1_0000);
    if (k < 8)
      return dpvt_pkg::RATE_W'(int'($urandom_range(2 * c_maxr)) - int'(c_maxr));
    return dpvt_pkg::RATE_W'($urandom);
  endfunction

  function automatic logic [dpvt_pkg::BLEN_W-1:0] rnd_blen();
    int k;
    k = $urandom_range(19);
    if (k == 0) return 13'd0;
    if (k == 1) return dpvt_pkg::BLEN_W'($urandom);
    if (k == 2) return 13'd4096;
    return dpvt_pkg::BLEN_W'($urandom_range(64, 1));
  endfunction

  initial begin
    int phase_words, ticks;
    logic [31:0] ls;
    reset_tracker();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset gains, no loop, plain track clamp off.
    write_reg(dpvt_pkg::REG_MAX_ABS_RATE, 32'd262144);
    write_reg(dpvt_pkg::REG_POS_GAIN, 32'd198996);
    write_reg(dpvt_pkg::REG_VEL_GAIN, 32'd58469881);
    write_reg(dpvt_pkg::REG_LOOP_ENABLE, 32'd0);
    write_reg(dpvt_pkg::REG_LOOP_START, 32'd0);
    write_reg(dpvt_pkg::REG_LOOP_END, 32'd0);
    write_reg(dpvt_pkg::REG_TRACK_LENGTH, 32'd0);
    // tick before any block start runs on zero reference
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_SEEK, 48'sh0000_0010_0000, 24'sh01_0000, '0, '0);
    // block length zero, lead zero, negative target position
    push_word(dpvt_pkg::OP_BLOCK, -48'sh1_0000, 24'sh01_0000, 12'd0, 13'd0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    // lead and block length beyond their bounds
    push_word(dpvt_pkg::OP_BLOCK, 48'sh0000_0100_0000, 24'sh7F_FFFF, 12'hFFF, 13'h1FFF);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(OP_UNUSED, 48'sh7FFF_FFFF_FFFF, 24'sh7F_FFFF, 12'hFFF, 13'h1FFF);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    // seek to the extremes with unclamped rate, then guard pulls the head back
    push_word(dpvt_pkg::OP_SEEK, 48'sh7FFF_FFFF_FFFF, 24'sh80_0000, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_SEEK, 48'sh8000_0000_0000, 24'sh7F_FFFF, '0, '0);
    push_word(dpvt_pkg::OP_BLOCK, 48'sh7FFF_FFFF_FFFF, 24'sh80_0000, 12'd96, 13'd4096);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_BLOCK, 48'sh0, 24'sh80_0000, 12'd1440, 13'd1);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    push_word(dpvt_pkg::OP_TICK, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Extremes on the first phases, random settings afterwards.
      no_idle = (ph == 2);
      ls = (ph == 1) ? 32'hFFFF_FFF0 : $urandom_range(20000);
      write_reg(dpvt_pkg::REG_MAX_ABS_RATE, ph == 0 ? 32'd0 : (ph == 1 ? 32'h7F_FFFF
                                  : $urandom_range(32'h8_0000, 32'h1_0000)));
      write_reg(dpvt_pkg::REG_POS_GAIN, ph < 2 ? (ph == 0 ? 32'd0 : 32'hFFFF_FFFF)
                                     : pick32($urandom_range(4000000, 1000)));
      write_reg(dpvt_pkg::REG_VEL_GAIN, ph < 2 ? (ph == 0 ? 32'd0 : 32'hFFFF_FFFF)
                                     : pick32($urandom_range(300000000, 1000000)));
      write_reg(dpvt_pkg::REG_LOOP_ENABLE, (ph == 1 || ph % 2 == 1) ? 32'd1 : 32'd0);
      write_reg(dpvt_pkg::REG_LOOP_START, ls);
      write_reg(dpvt_pkg::REG_LOOP_END, ph == 1 ? 32'hFFFF_FFFF :
                              (ph == 3 ? ls + 1 : ls + $urandom_range(50000, 2)));
      write_reg(dpvt_pkg::REG_TRACK_LENGTH, ph == 1 ? 32'hFFFF_FFFF :
                                  (ph == 4 ? 32'd1 : pick32($urandom_range(400000, 2))));
      phase_words = 0;
      while (phase_words < 235) begin
        if ($urandom_range(9) < 3) begin
          push_word(dpvt_pkg::OP_SEEK, rnd_pos(), rnd_rate(),
                    dpvt_pkg::LEAD_W'($urandom), dpvt_pkg::BLEN_W'($urandom));
          phase_words++;
        end
        if ($urandom_range(19) != 0) begin
          push_word(dpvt_pkg::OP_BLOCK, rnd_pos(), rnd_rate(),
                    dpvt_pkg::LEAD_W'($urandom), rnd_blen());
          phase_words++;
        end
        ticks = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
        repeat (ticks) begin
          // noise words that the block ignores
          if ($urandom_range(29) == 0)
            push_word(OP_UNUSED, dpvt_pkg::POS_W'({$urandom, $urandom}),
                      dpvt_pkg::RATE_W'($urandom),
                      dpvt_pkg::LEAD_W'($urandom), dpvt_pkg::BLEN_W'($urandom));
          push_word(dpvt_pkg::OP_TICK, dpvt_pkg::POS_W'({$urandom, $urandom}),
                    dpvt_pkg::RATE_W'($urandom),
                    dpvt_pkg::LEAD_W'($urandom), dpvt_pkg::BLEN_W'($urandom));
          phase_words++;
        end
      end
      drain();
    end

    $display("Covered %0d command words over %0d register settings, %0d samples checked.",
             words_sent, PHASES + 1, samples_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out waiting for the tracker.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
hdl/dpvt_pkg.sv
hdl/dpvt_div.sv
hdl/dpvt_ctrl.sv
hdl/dpvt_dp.sv
hdl/damped_position_velocity_tracker_core.sv
tb/damped_position_velocity_tracker_core_tb.sv
